FILE: rtl/scnseg_pkg.sv
// Shared constants for the scan object segmenter: field widths, register
// indexes and reset values. No dependencies.
`timescale 1ns / 1ps
package scnseg_pkg;

   localparam int MAX_SAMPLES_DEF = 128;
   localparam int ANGLE_STEP_DEF  = 2;

   localparam int DIST_W  = 16;
   localparam int ANGLE_W = 9;
   localparam int NUM_W   = 6;
   localparam int TOL_W   = 8;
   localparam int PAIR_W  = 7;
   localparam int SUM_W   = 23;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PAIRS   = 2'd2;

   localparam logic [DIST_W-1:0]  RANGE_LIMIT_RST = 16'd100;
   localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 8'd4;
   localparam logic [PAIR_W-1:0]  MIN_PAIRS_RST   = 7'd4;
   localparam logic [ANGLE_W-1:0] WIDTH_SENTINEL  = 9'h1FF;
   localparam logic [NUM_W-1:0]   OBJ_NUM_MAX     = 6'd63;
   localparam logic [PAIR_W-1:0]  PAIR_MAX        = 7'd127;

endpackage

FILE: rtl/scan_object_segmenter_core.sv
// Scan object segmenter top level: sample sequencer, run tracking, smallest
// object record and result register. Depends on scnseg_pkg and scnseg_div.
//
//   channel | direction | ports                               | handshake
//   req     | in        | distance, last_sample               | req_valid / req_stall
//   rsp     | out       | is_summary .. last (8 fields)       | rsp_valid / rsp_stall
//   csr     | in        | csr_index, csr_wdata                | csr_wr_en
//
// A sample is captured, then evaluated; closing an object runs the serial
// divider for the average, one quotient bit per cycle over 23 bits. A scan
// end adds the summary. Reset is synchronous and clears control and scan
// state, not data registers. A stalled result holds the sequencer in its
// output state; the next sample is taken while the last result still waits.
`timescale 1ns / 1ps
module scan_object_segmenter_core import scnseg_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int ANGLE_STEP  = ANGLE_STEP_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DIST_W-1:0]     req_distance,
   input  logic                  req_last_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_is_summary,
   output logic [NUM_W-1:0]      rsp_object_number,
   output logic [ANGLE_W-1:0]    rsp_start_angle,
   output logic [ANGLE_W-1:0]    rsp_end_angle,
   output logic [DIST_W-1:0]     rsp_avg_distance,
   output logic [ANGLE_W-1:0]    rsp_width,
   output logic                  rsp_found,
   output logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_OBJ  = 3'd3;
   localparam logic [2:0] ST_SUMM = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [DIST_W-1:0]  range_limit_ff, range_limit_in;
   logic [TOL_W-1:0]   tolerance_ff, tolerance_in;
   logic [PAIR_W-1:0]  min_pairs_ff, min_pairs_in;

   logic [DIST_W-1:0]  cur_ff, cur_in;
   logic               last_flag_ff, last_flag_in;
   logic               end_ff, end_in;
   logic [DIST_W-1:0]  prev_ff, prev_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PAIR_W-1:0]  pairs_ff, pairs_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [NUM_W-1:0]   objs_ff, objs_in;
   logic [ANGLE_W-1:0] sm_width_ff, sm_width_in;
   logic [ANGLE_W-1:0] sm_angle_ff, sm_angle_in;
   logic [DIST_W-1:0]  sm_dist_ff, sm_dist_in;
   logic               any_ff, any_in;

   logic [CNT_W-1:0]   obj_end_ff, obj_end_in;
   logic [CNT_W-1:0]   obj_cnt_ff, obj_cnt_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_summ_ff, out_summ_in;
   logic [NUM_W-1:0]   out_num_ff, out_num_in;
   logic [ANGLE_W-1:0] out_start_ff, out_start_in;
   logic [ANGLE_W-1:0] out_end_ff, out_end_in;
   logic [DIST_W-1:0]  out_avg_ff, out_avg_in;
   logic [ANGLE_W-1:0] out_width_ff, out_width_in;
   logic               out_found_ff, out_found_in;
   logic               out_last_ff, out_last_in;

   logic               div_start;
   logic [SUM_W-1:0]   div_dividend;
   logic               div_done;
   logic [SUM_W-1:0]   div_quotient;

   logic               req_xfer;
   logic               out_free;
   logic [PAIR_W-1:0]  need;
   logic               close;
   logic [PAIR_W-1:0]  pairs_up;
   logic [SUM_W-1:0]   sum_up;
   logic [ANGLE_W-1:0] obj_width;
   logic [ANGLE_W-1:0] obj_start;
   logic [ANGLE_W-1:0] obj_end_angle;
   logic [NUM_W-1:0]   objs_up;

   assign req_xfer = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !out_valid_ff || !rsp_stall;
   assign need = (min_pairs_ff == '0) ? PAIR_W'(1) : min_pairs_ff;

   always_comb begin
      close = ({1'b0, cur_ff} + {9'b0, tolerance_ff} > {1'b0, prev_ff})
           && ({1'b0, prev_ff} + {9'b0, tolerance_ff} > {1'b0, cur_ff})
           && (prev_ff < range_limit_ff);
      pairs_up = (pairs_ff < PAIR_MAX) ? pairs_ff + PAIR_W'(1) : pairs_ff;
      sum_up = (pairs_ff == '0) ? SUM_W'(prev_ff) + SUM_W'(cur_ff)
                                : sum_ff + SUM_W'(cur_ff);
      obj_width = ANGLE_W'(obj_cnt_ff) * ANGLE_W'(ANGLE_STEP);
      obj_start = (ANGLE_W'(obj_end_ff) - ANGLE_W'(obj_cnt_ff)) * ANGLE_W'(ANGLE_STEP);
      obj_end_angle = ANGLE_W'(obj_end_ff) * ANGLE_W'(ANGLE_STEP);
      objs_up = (objs_ff < OBJ_NUM_MAX) ? objs_ff + NUM_W'(1) : objs_ff;
   end

   always_comb begin
      range_limit_in = range_limit_ff;
      tolerance_in   = tolerance_ff;
      min_pairs_in   = min_pairs_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RANGE_LIMIT: range_limit_in = csr_wdata;
            CSR_TOLERANCE:   tolerance_in   = csr_wdata[TOL_W-1:0];
            CSR_MIN_PAIRS:   min_pairs_in   = csr_wdata[PAIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      last_flag_in = last_flag_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      idx_in       = idx_ff;
      pairs_in     = pairs_ff;
      sum_in       = sum_ff;
      objs_in      = objs_ff;
      sm_width_in  = sm_width_ff;
      sm_angle_in  = sm_angle_ff;
      sm_dist_in   = sm_dist_ff;
      any_in       = any_ff;
      obj_end_in   = obj_end_ff;
      obj_cnt_in   = obj_cnt_ff;
      div_start    = 1'b0;
      div_dividend = sum_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_summ_in  = out_summ_ff;
      out_num_in   = out_num_ff;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_avg_in   = out_avg_ff;
      out_width_in = out_width_ff;
      out_found_in = out_found_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cur_in       = req_distance;
               last_flag_in = req_last_sample;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            end_in   = last_flag_ff || (idx_ff >= IDX_W'(MAX_SAMPLES - 1));
            state_in = end_in ? ST_SUMM : ST_IDLE;
            if (idx_ff != '0) begin
               if (close) begin
                  pairs_in   = pairs_up;
                  sum_in     = sum_up;
                  obj_cnt_in = CNT_W'(pairs_up) + CNT_W'(1);
                  obj_end_in = CNT_W'(idx_ff) + CNT_W'(1);
                  if (end_in && pairs_up >= need) begin
                     div_start    = 1'b1;
                     div_dividend = sum_up;
                     state_in     = ST_DIV;
                  end
               end else begin
                  obj_cnt_in = CNT_W'(pairs_ff) + CNT_W'(1);
                  obj_end_in = CNT_W'(idx_ff);
                  if (pairs_ff >= need) begin
                     div_start    = 1'b1;
                     div_dividend = sum_ff;
                     state_in     = ST_DIV;
                  end
                  pairs_in = '0;
                  sum_in   = '0;
               end
            end
            prev_in = cur_ff;
            if (end_in) begin
               idx_in   = '0;
               pairs_in = '0;
               sum_in   = '0;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OBJ;
            end
         end
         ST_OBJ: begin
            if (out_free) begin
               objs_in = objs_up;
               if (!any_ff || obj_width < sm_width_ff) begin
                  sm_width_in = obj_width;
                  sm_angle_in = obj_start;
                  sm_dist_in  = div_quotient[DIST_W-1:0];
                  any_in      = 1'b1;
               end
               out_valid_in = 1'b1;
               out_summ_in  = 1'b0;
               out_num_in   = objs_up;
               out_start_in = obj_start;
               out_end_in   = obj_end_angle;
               out_avg_in   = div_quotient[DIST_W-1:0];
               out_width_in = obj_width;
               out_found_in = 1'b0;
               out_last_in  = !end_ff;
               state_in     = end_ff ? ST_SUMM : ST_IDLE;
            end
         end
         ST_SUMM: begin
            if (out_free) begin
               objs_in      = '0;
               out_valid_in = 1'b1;
               out_summ_in  = 1'b1;
               out_num_in   = '0;
               out_start_in = any_ff ? sm_angle_ff : '0;
               out_end_in   = '0;
               out_avg_in   = any_ff ? sm_dist_ff : '0;
               out_width_in = any_ff ? sm_width_ff : '0;
               out_found_in = any_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         range_limit_ff <= RANGE_LIMIT_RST;
         tolerance_ff   <= TOLERANCE_RST;
         min_pairs_ff   <= MIN_PAIRS_RST;
         end_ff         <= 1'b0;
         prev_ff        <= '0;
         idx_ff         <= '0;
         pairs_ff       <= '0;
         sum_ff         <= '0;
         objs_ff        <= '0;
         sm_width_ff    <= WIDTH_SENTINEL;
         sm_angle_ff    <= '0;
         sm_dist_ff     <= '0;
         any_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         range_limit_ff <= range_limit_in;
         tolerance_ff   <= tolerance_in;
         min_pairs_ff   <= min_pairs_in;
         end_ff         <= end_in;
         prev_ff        <= prev_in;
         idx_ff         <= idx_in;
         pairs_ff       <= pairs_in;
         sum_ff         <= sum_in;
         objs_ff        <= objs_in;
         sm_width_ff    <= sm_width_in;
         sm_angle_ff    <= sm_angle_in;
         sm_dist_ff     <= sm_dist_in;
         any_ff         <= any_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      last_flag_ff <= last_flag_in;
      obj_end_ff   <= obj_end_in;
      obj_cnt_ff   <= obj_cnt_in;
      out_summ_ff  <= out_summ_in;
      out_num_ff   <= out_num_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_avg_ff   <= out_avg_in;
      out_width_ff <= out_width_in;
      out_found_ff <= out_found_in;
      out_last_ff  <= out_last_in;
   end

   scnseg_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (obj_cnt_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_is_summary    = out_summ_ff;
   assign rsp_object_number = out_num_ff;
   assign rsp_start_angle   = out_start_ff;
   assign rsp_end_angle     = out_end_ff;
   assign rsp_avg_distance  = out_avg_ff;
   assign rsp_width         = out_width_ff;
   assign rsp_found         = out_found_ff;
   assign rsp_last          = out_last_ff;

endmodule

FILE: rtl/scnseg_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on scnseg_pkg for the default dividend width.
`timescale 1ns / 1ps
module scnseg_div import scnseg_pkg::*; #(
   parameter int DVD_W = SUM_W,
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: bench/scan_object_segmenter_core_tb.sv
// Testbench for scan_object_segmenter_core: directed probe table, then phases of
// random scans under changing register settings, with self-checking prediction.
// Depends on scnseg_pkg and the core RTL only.
`timescale 1ns / 1ps
module scan_object_segmenter_core_tb import scnseg_pkg::*; ();

   localparam int PROBE_ROWS    = 25;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 165;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic               is_summary;
      logic [NUM_W-1:0]   object_number;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] end_angle;
      logic [DIST_W-1:0]  avg_distance;
      logic [ANGLE_W-1:0] width;
      logic               found;
      logic               last;
   } scan_rec_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              lst;
      logic              typed;
      scan_rec_type      rec;
   } probe_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DIST_W-1:0]     req_distance = '0;
   logic                  req_last_sample = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_is_summary;
   logic [NUM_W-1:0]      rsp_object_number;
   logic [ANGLE_W-1:0]    rsp_start_angle;
   logic [ANGLE_W-1:0]    rsp_end_angle;
   logic [DIST_W-1:0]     rsp_avg_distance;
   logic [ANGLE_W-1:0]    rsp_width;
   logic                  rsp_found;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow registers and scan state of the predictor
   logic [DIST_W-1:0]  range_q     = RANGE_LIMIT_RST;
   logic [TOL_W-1:0]   tol_q       = TOLERANCE_RST;
   logic [PAIR_W-1:0]  min_pairs_q = MIN_PAIRS_RST;
   logic [DIST_W-1:0]  prev_dist   = '0;
   logic [PAIR_W-1:0]  scan_idx    = '0;
   logic [PAIR_W-1:0]  pair_cnt    = '0;
   int unsigned        run_total   = 0;
   logic [NUM_W-1:0]   obj_count   = '0;
   logic [ANGLE_W-1:0] best_width  = WIDTH_SENTINEL;
   logic [ANGLE_W-1:0] best_angle  = '0;
   logic [DIST_W-1:0]  best_dist   = '0;
   logic               any_obj     = 1'b0;

   scan_rec_type  step_recs [2];
   scan_rec_type  due_records [$];
   probe_row_type probe_rows [PROBE_ROWS];
   int            fail_count = 0;
   int            fed_items = 0;
   bit            feed_calm = 1'b0;
   bit            drain_calm = 1'b0;

   scan_object_segmenter_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_distance      (req_distance),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_object_number (rsp_object_number),
      .rsp_start_angle   (rsp_start_angle),
      .rsp_end_angle     (rsp_end_angle),
      .rsp_avg_distance  (rsp_avg_distance),
      .rsp_width         (rsp_width),
      .rsp_found         (rsp_found),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic scan_rec_type summary_rec(input int unsigned first,
                                                input int unsigned avg,
                                                input int unsigned span, input logic fnd);
      scan_rec_type rec;
      rec = '0;
      rec.is_summary   = 1'b1;
      rec.start_angle  = ANGLE_W'(first);
      rec.avg_distance = DIST_W'(avg);
      rec.width        = ANGLE_W'(span);
      rec.found        = fnd;
      rec.last         = 1'b1;
      return rec;
   endfunction

   function automatic void close_object(input int unsigned end_idx, output scan_rec_type rec);
      int unsigned samples, avg, span, first;
      samples = int'(pair_cnt) + 1;
      avg     = run_total / samples;
      span    = ANGLE_STEP_DEF * samples;
      first   = (end_idx - samples) * ANGLE_STEP_DEF;
      if (obj_count < OBJ_NUM_MAX) obj_count++;
      if (!any_obj || span < best_width) begin
         best_width = ANGLE_W'(span);
         best_angle = ANGLE_W'(first);
         best_dist  = DIST_W'(avg);
         any_obj    = 1'b1;
      end
      rec = '0;
      rec.object_number = obj_count;
      rec.start_angle   = ANGLE_W'(first);
      rec.end_angle     = ANGLE_W'(end_idx * ANGLE_STEP_DEF);
      rec.avg_distance  = DIST_W'(avg);
      rec.width         = ANGLE_W'(span);
   endfunction

   // advance the segmenter by one sample; results land in step_recs
   function automatic int segment_sample(input logic [DIST_W-1:0] distance, input logic lst);
      int unsigned cur, prev, need;
      logic        at_end, is_close;
      int          n;
      cur    = 32'(distance);
      n      = 0;
      at_end = lst || (int'(scan_idx) >= MAX_SAMPLES_DEF - 1);
      need   = (min_pairs_q == 0) ? 1 : int'(min_pairs_q);
      if (scan_idx != 0) begin
         prev     = 32'(prev_dist);
         is_close = (cur + tol_q > prev) && (prev + tol_q > cur) && (prev < range_q);
         if (is_close) begin
            if (pair_cnt == 0) run_total = prev + cur;
            else run_total += cur;
            if (pair_cnt < PAIR_MAX) pair_cnt++;
         end else begin
            if (pair_cnt >= need) begin
               close_object(int'(scan_idx), step_recs[n]);
               n++;
            end
            pair_cnt  = '0;
            run_total = 0;
         end
      end
      if (at_end) begin
         if (pair_cnt >= need) begin
            close_object(int'(scan_idx) + 1, step_recs[n]);
            n++;
         end
         if (any_obj) step_recs[n] = summary_rec(best_angle, best_dist, best_width, 1'b1);
         else step_recs[n] = summary_rec(0, 0, 0, 1'b0);
         n++;
         scan_idx  = '0;
         pair_cnt  = '0;
         run_total = 0;
         obj_count = '0;
      end else begin
         scan_idx = scan_idx + 1'b1;
      end
      prev_dist = distance;
      for (int k = 0; k < n; k++) step_recs[k].last = (k == n - 1);
      return n;
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_base();
      if (range_q == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
      return $urandom_range(0, int'(range_q) - 1);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic transfer_sample(input logic [DIST_W-1:0] distance, input logic lst,
                                  input logic typed, input scan_rec_type typed_rec);
      int gap, n;
      if ($urandom_range(0, 99) < 2) feed_calm = !feed_calm;
      gap = pick_gap(feed_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_distance    <= distance;
      req_last_sample <= lst;
      do @(posedge clock); while (req_stall);
      fed_items++;
      n = segment_sample(distance, lst);
      if (typed) due_records.push_back(typed_rec);
      else for (int k = 0; k < n; k++) due_records.push_back(step_recs[k]);
   endtask

   task automatic send_scan(input int len, input bit noisy);
      int v, stride, r;
      v = pick_base();
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (noisy || r >= 95) begin
            v = $urandom_range(0, 65535);
         end else if (r >= 80) begin
            v = pick_base();
         end else begin
            // hit the tolerance edge now and then
            stride = (tol_q == 0) ? $urandom_range(0, 2)
                                  : $urandom_range(0, int'(tol_q) - 1 + (r < 8));
            v = $urandom_range(0, 1) ? v + stride : v - stride;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
         end
         transfer_sample(v[DIST_W-1:0], i == len - 1, 1'b0, '0);
      end
   endtask

   // drop valid and wait until the core has drained
   task automatic settle();
      req_valid <= 1'b0;
      while (due_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [DIST_W-1:0] lim, input logic [TOL_W-1:0] tol,
                               input logic [PAIR_W-1:0] pairs);
      logic [CSR_DATA_W-1:0] vals [3];
      logic [CSR_IDX_W-1:0]  regs [3];
      vals = '{lim, CSR_DATA_W'(tol), CSR_DATA_W'(pairs)};
      regs = '{CSR_RANGE_LIMIT, CSR_TOLERANCE, CSR_MIN_PAIRS};
      csr_wr_en <= 1'b1;
      for (int k = 0; k < 3; k++) begin
         csr_index <= regs[k];
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_wr_en   <= 1'b0;
      range_q     = lim;
      tol_q       = tol;
      min_pairs_q = pairs;
   endtask

   initial begin : rsp_stall_gen
      int n;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 99) < 5) drain_calm = !drain_calm;
         n = pick_gap(drain_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      scan_rec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_records.size() == 0) begin
            $error("result transfer with no record due");
            fail_count++;
         end else begin
            want = due_records.pop_front();
            check_field("is_summary", want.is_summary, rsp_is_summary);
            check_field("object_number", want.object_number, rsp_object_number);
            check_field("start_angle", want.start_angle, rsp_start_angle);
            check_field("end_angle", want.end_angle, rsp_end_angle);
            check_field("avg_distance", want.avg_distance, rsp_avg_distance);
            check_field("width", want.width, rsp_width);
            check_field("found", want.found, rsp_found);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin : stimulus
      int mark, r;
      probe_rows = '{
         '{16'd0,     1'b1, 1'b1, summary_rec(0, 0, 0, 1'b0)},
         '{16'd65535, 1'b1, 1'b1, summary_rec(0, 0, 0, 1'b0)},
         '{16'd10,    1'b0, 1'b0, '0},
         '{16'd11,    1'b0, 1'b0, '0},
         '{16'd12,    1'b0, 1'b0, '0},
         '{16'd13,    1'b0, 1'b0, '0},
         '{16'd14,    1'b0, 1'b0, '0},
         '{16'd200,   1'b0, 1'b0, '0},
         '{16'd50,    1'b0, 1'b0, '0},
         '{16'd51,    1'b0, 1'b0, '0},
         '{16'd52,    1'b0, 1'b0, '0},
         '{16'd53,    1'b0, 1'b0, '0},
         '{16'd54,    1'b1, 1'b0, '0},
         '{16'd7,     1'b1, 1'b1, summary_rec(0, 12, 10, 1'b1)},
         '{16'd30,    1'b0, 1'b0, '0},
         '{16'd33,    1'b0, 1'b0, '0},
         '{16'd36,    1'b0, 1'b0, '0},
         '{16'd39,    1'b0, 1'b0, '0},
         '{16'd42,    1'b0, 1'b0, '0},
         '{16'd46,    1'b0, 1'b0, '0},
         '{16'd97,    1'b0, 1'b0, '0},
         '{16'd98,    1'b0, 1'b0, '0},
         '{16'd99,    1'b0, 1'b0, '0},
         '{16'd100,   1'b0, 1'b0, '0},
         '{16'd101,   1'b1, 1'b0, '0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (probe_rows[k])
         transfer_sample(probe_rows[k].distance, probe_rows[k].lst, probe_rows[k].typed,
                         probe_rows[k].rec);

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         mark = fed_items;
         case (phase)
            0: write_config(RANGE_LIMIT_RST, TOLERANCE_RST, MIN_PAIRS_RST);
            1: begin
               write_config(16'd65535, 8'd255, PAIR_MAX);
               // one run across the whole scan
               for (int i = 0; i < MAX_SAMPLES_DEF; i++)
                  transfer_sample(DIST_W'(40000 + i % 3), i == MAX_SAMPLES_DEF - 1, 1'b0, '0);
            end
            2: write_config(16'd0, 8'd4, 7'd1);
            3: write_config(16'd500, 8'd0, 7'd2);
            4: write_config(16'd1000, 8'd16, 7'd0);
            5: begin
               write_config(16'd100, 8'd4, 7'd1);
               // alternate across the range limit: one object every two samples
               for (int i = 0; i < MAX_SAMPLES_DEF; i++)
                  transfer_sample(DIST_W'(99 + i % 2), i == MAX_SAMPLES_DEF - 1, 1'b0, '0);
            end
            default: begin
               if ($urandom_range(0, 1))
                  write_config(DIST_W'($urandom_range(50, 2000)),
                               TOL_W'($urandom_range(1, 64)),
                               PAIR_W'($urandom_range(1, 6)));
               else
                  write_config(DIST_W'($urandom_range(0, 65535)),
                               TOL_W'($urandom_range(0, 255)),
                               PAIR_W'($urandom_range(0, 8)));
            end
         endcase
         while (fed_items - mark < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            send_scan((r < 5) ? $urandom_range(128, 130) : $urandom_range(1, 24),
                      $urandom_range(0, 99) < 15);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("[scan_object_segmenter_core] OK");
      end else begin
         $display("[scan_object_segmenter_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #50_000_000;
      $display("[scan_object_segmenter_core] ERROR");
      $finish;
   end

endmodule

FILE: scan_object_segmenter_core.f
rtl/scnseg_pkg.sv
rtl/scnseg_div.sv
rtl/scan_object_segmenter_core.sv
bench/scan_object_segmenter_core_tb.sv
